// File: rtl/core/a2l_pkg.sv
// Shared types and constants for the Annex B to length-prefixed NAL converter.
package a2l_pkg;

  localparam logic [4:0] TYPE_MASK   = 5'h1F;
  localparam logic [4:0] TYPE_IDR    = 5'd5;
  localparam logic [4:0] TYPE_SPS    = 5'd7;
  localparam logic [4:0] TYPE_PPS    = 5'd8;
  localparam logic [4:0] TYPE_AUD    = 5'd9;
  localparam logic [4:0] TYPE_FILLER = 5'd12;

  localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
  localparam logic [1:0] KIND_DESC     = 2'd1;
  localparam logic [1:0] KIND_UNIT_END = 2'd2;

  localparam logic [1:0] STREAM_SAMPLE = 2'd0;
  localparam logic [1:0] STREAM_SPS    = 2'd1;
  localparam logic [1:0] STREAM_PPS    = 2'd2;

  // One command per input byte that causes any result.
  typedef struct packed {
    logic [7:0]  byte_val;
    logic        byte_en;     // non-zero byte closes the payload run
    logic [2:0]  npay;        // payload results, zeros first
    logic [1:0]  pay_stream;
    logic [4:0]  pay_type;
    logic        desc_en;
    logic [1:0]  desc_stream;
    logic [4:0]  desc_type;
    logic [31:0] desc_len;
    logic        end_en;
    logic        idr;
    logic [2:0]  tot;         // total results of this command
  } cmd_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [1:0]  kind;
    logic [1:0]  stream;
    logic [4:0]  nal_kind;
    logic [31:0] nal_length;
    logic        idr_seen;
    logic        last;
  } res_t;

endpackage

// File: rtl/core/a2l_if.sv
// Valid/ready channel interfaces for the byte input and the result output.
interface a2l_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       unit_end;

  modport source(output valid, output in_byte, output unit_end, input ready);
  modport sink(input valid, input in_byte, input unit_end, output ready);
endinterface

interface a2l_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [1:0]  kind;
  logic [1:0]  stream;
  logic [4:0]  nal_kind;
  logic [31:0] nal_length;
  logic        idr_seen;
  logic        last;

  modport source(output valid, output out_byte, output kind, output stream,
                 output nal_kind, output nal_length, output idr_seen,
                 output last, input ready);
  modport sink(input valid, input out_byte, input kind, input stream,
               input nal_kind, input nal_length, input idr_seen,
               input last, output ready);
endinterface

// File: rtl/core/a2l_front.sv
// Front end: start code tracking, NAL classification and command building.
module a2l_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           acc,
  input  logic [7:0]     in_byte,
  input  logic           unit_end,
  output logic           push,
  output a2l_pkg::cmd_t  cmd
);
  import a2l_pkg::*;

  logic [1:0]  held_r, held_nxt;
  logic        inside_r, inside_nxt;
  logic        first_r, first_nxt;
  logic [4:0]  type_r, type_nxt;
  logic [1:0]  class_r, class_nxt;
  logic        drop_r, drop_nxt;
  logic [31:0] cnt_r, cnt_nxt;
  logic        idr_r, idr_nxt;

  logic        is_zero, is_sc, bm;
  logic [2:0]  z_main, z, m;
  logic [1:0]  h_after;
  logic [4:0]  t_new, type_eff;
  logic [1:0]  class_new, class_eff;
  logic        drop_new, drop_eff, first_eff, idr_eff, set_type, pay_en;
  logic [32:0] sum;
  logic [31:0] cnt_eff;

  always_comb begin
    is_zero = (in_byte == 8'd0);
    is_sc   = (in_byte == 8'd1) && (held_r >= 2'd2);
    z_main  = 3'd0;
    bm      = 1'b0;
    h_after = 2'd0;
    if (is_zero) begin
      if (held_r == 2'd3) begin
        z_main  = 3'd1;
        h_after = 2'd3;
      end else begin
        h_after = 2'(held_r + 2'd1);
      end
    end else if (!is_sc) begin
      z_main = 3'(held_r);
      bm     = 1'b1;
    end
    // held zeros flush at the end of the unit, after the main-part bytes
    z = z_main + (unit_end ? 3'(h_after) : 3'd0);
    m = z + 3'(bm);

    // a released zero as first byte sets type 0
    t_new = (z != 3'd0) ? 5'd0 : (in_byte[4:0] & TYPE_MASK);
    unique case (t_new) inside
      TYPE_SPS: class_new = STREAM_SPS;
      TYPE_PPS: class_new = STREAM_PPS;
      default:  class_new = STREAM_SAMPLE;
    endcase
    drop_new = (t_new == TYPE_AUD) || (t_new == TYPE_FILLER);

    set_type  = !is_sc && inside_r && first_r && (m != 3'd0);
    type_eff  = set_type ? t_new : type_r;
    class_eff = set_type ? class_new : class_r;
    drop_eff  = set_type ? drop_new : drop_r;
    first_eff = set_type ? 1'b0 : first_r;
    idr_eff   = idr_r | (set_type && (t_new == TYPE_IDR));

    sum     = {1'b0, cnt_r} + 33'(m);
    cnt_eff = (inside_r && !is_sc) ? (sum[32] ? 32'hFFFF_FFFF : sum[31:0]) : cnt_r;
    pay_en  = !is_sc && inside_r && !drop_eff && (m != 3'd0);

    cmd.byte_val   = in_byte;
    cmd.byte_en    = bm;
    cmd.npay       = pay_en ? m : 3'd0;
    cmd.pay_stream = class_eff;
    cmd.pay_type   = type_eff;
    if (is_sc) begin
      cmd.desc_en     = inside_r && !first_r && !drop_r;
      cmd.desc_stream = class_r;
      cmd.desc_type   = type_r;
      cmd.desc_len    = cnt_r;
    end else begin
      cmd.desc_en     = unit_end && inside_r && !first_eff && !drop_eff;
      cmd.desc_stream = class_eff;
      cmd.desc_type   = type_eff;
      cmd.desc_len    = cnt_eff;
    end
    cmd.end_en = unit_end;
    cmd.idr    = idr_eff;
    cmd.tot    = cmd.npay + 3'(cmd.desc_en) + 3'(unit_end);
    push       = acc && (cmd.tot != 3'd0);

    // next state
    held_nxt   = held_r;
    inside_nxt = inside_r;
    first_nxt  = first_r;
    type_nxt   = type_r;
    class_nxt  = class_r;
    drop_nxt   = drop_r;
    cnt_nxt    = cnt_r;
    idr_nxt    = idr_r;
    if (acc) begin
      if (unit_end) begin
        held_nxt   = 2'd0;
        inside_nxt = 1'b0;
        first_nxt  = 1'b0;
        type_nxt   = 5'd0;
        class_nxt  = STREAM_SAMPLE;
        drop_nxt   = 1'b0;
        cnt_nxt    = 32'd0;
        idr_nxt    = 1'b0;
      end else if (is_sc) begin
        held_nxt   = 2'd0;
        inside_nxt = 1'b1;
        first_nxt  = 1'b1;
        type_nxt   = 5'd0;
        class_nxt  = STREAM_SAMPLE;
        drop_nxt   = 1'b0;
        cnt_nxt    = 32'd0;
      end else begin
        held_nxt  = h_after;
        first_nxt = first_eff;
        type_nxt  = type_eff;
        class_nxt = class_eff;
        drop_nxt  = drop_eff;
        cnt_nxt   = cnt_eff;
        idr_nxt   = idr_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r   <= 2'd0;
      inside_r <= 1'b0;
      first_r  <= 1'b0;
      type_r   <= 5'd0;
      class_r  <= STREAM_SAMPLE;
      drop_r   <= 1'b0;
      cnt_r    <= 32'd0;
      idr_r    <= 1'b0;
    end else begin
      held_r   <= held_nxt;
      inside_r <= inside_nxt;
      first_r  <= first_nxt;
      type_r   <= type_nxt;
      class_r  <= class_nxt;
      drop_r   <= drop_nxt;
      cnt_r    <= cnt_nxt;
      idr_r    <= idr_nxt;
    end
  end

endmodule

// File: rtl/core/a2l_queue.sv
// Small command queue between front and back end.
module a2l_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  a2l_pkg::cmd_t  din,
  input  logic           pop,
  output a2l_pkg::cmd_t  dout,
  output logic           full,
  output logic           empty
);
  import a2l_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem_r [DEPTH];
  logic [PW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  always_comb begin
    full    = (cnt_r == CW'(DEPTH));
    empty   = (cnt_r == '0);
    dout    = mem_r[rd_r];
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == PW'(DEPTH - 1)) ? '0 : PW'(wr_r + 1'b1);
    end
    if (pop) begin
      rd_nxt = (rd_r == PW'(DEPTH - 1)) ? '0 : PW'(rd_r + 1'b1);
    end
    if (push && !pop) begin
      cnt_nxt = CW'(cnt_r + 1'b1);
    end else if (pop && !push) begin
      cnt_nxt = CW'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: rtl/core/a2l_back.sv
// Back end: expand a command into results in the output register, one per unstalled cycle.
module a2l_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           head_valid,
  input  a2l_pkg::cmd_t  head,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output a2l_pkg::res_t  res
);
  import a2l_pkg::*;

  logic [2:0] pos_r, pos_nxt;
  logic       out_valid_r, out_valid_nxt;
  res_t       res_r, res_nxt;
  logic       load, adv, last;

  always_comb begin
    load = !out_valid_r || out_ready;
    adv  = load && head_valid;
    last = (3'(pos_r + 3'd1) == head.tot);
    pop  = adv && last;

    res_nxt            = '0;
    res_nxt.last       = last;
    if (pos_r < head.npay) begin
      res_nxt.kind     = KIND_PAYLOAD;
      res_nxt.stream   = head.pay_stream;
      res_nxt.nal_kind = head.pay_type;
      // the non-zero byte always comes after the released zeros
      res_nxt.out_byte = (head.byte_en && (3'(pos_r + 3'd1) == head.npay)) ?
                         head.byte_val : 8'd0;
    end else if ((pos_r == head.npay) && head.desc_en) begin
      res_nxt.kind       = KIND_DESC;
      res_nxt.stream     = head.desc_stream;
      res_nxt.nal_kind   = head.desc_type;
      res_nxt.nal_length = head.desc_len;
    end else begin
      res_nxt.kind     = KIND_UNIT_END;
      res_nxt.idr_seen = head.idr;
    end

    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = head_valid;
    end
    if (adv) begin
      pos_nxt = last ? 3'd0 : 3'(pos_r + 3'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign res       = res_r;

endmodule

// File: rtl/core/annexb_to_length_prefixed_nal_top.sv
// Top level of the Annex B to length-prefixed NAL converter.
//
//   channel | modport | carries
//   --------+---------+------------------------------------------------------
//   in_if   | sink    | in_byte, unit_end: one Annex B byte per request
//   out_if  | source  | out_byte, kind, stream, nal_kind, nal_length,
//           |         | idr_seen, last: one result per request
//
// Input: one byte per cycle while the command queue has room. A byte that causes
// n results (up to six) holds the back end until it has emitted them; the queue
// (QUEUE_DEPTH entries) lets the front keep taking bytes meanwhile, and in_if.ready
// drops only when it is full. Results pass through the queue, then the output register.
// Reset: synchronous, active low; no clearing pass, ready right after reset.
// Stalls on out_if hold the output register and fill the queue behind it.
module annexb_to_length_prefixed_nal_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  a2l_in_if.sink    in_if,
  a2l_out_if.source out_if
);
  import a2l_pkg::*;

  cmd_t front_cmd, head_cmd;
  res_t res;
  logic acc, push, pop, full, empty, out_valid;

  // Accept a byte whenever the queue has room for its command.
  assign in_if.ready = !full;
  assign acc         = in_if.valid && !full;

  a2l_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .in_byte  (in_if.in_byte),
    .unit_end (in_if.unit_end),
    .push     (push),
    .cmd      (front_cmd)
  );

  a2l_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (front_cmd),
    .pop   (pop),
    .dout  (head_cmd),
    .full  (full),
    .empty (empty)
  );

  a2l_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (!empty),
    .head       (head_cmd),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_if.ready),
    .res        (res)
  );

  // Drive the result channel from the output register.
  assign out_if.valid      = out_valid;
  assign out_if.out_byte   = res.out_byte;
  assign out_if.kind       = res.kind;
  assign out_if.stream     = res.stream;
  assign out_if.nal_kind   = res.nal_kind;
  assign out_if.nal_length = res.nal_length;
  assign out_if.idr_seen   = res.idr_seen;
  assign out_if.last       = res.last;

endmodule

// File: rtl/core/a2l_checker.sv
// Port-level checker for the converter, bound to the top level.
module a2l_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_byte,
  input logic [1:0]  kind,
  input logic [1:0]  stream,
  input logic [4:0]  nal_kind,
  input logic [31:0] nal_length,
  input logic        idr_seen,
  input logic        last
);
  import a2l_pkg::*;

  // hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(out_byte)
                                && $stable(nal_length) && $stable(last))
    else $error("stalled result changed");

  a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (kind == KIND_PAYLOAD) |-> (nal_length == 32'd0) && !idr_seen
                                            && (stream != 2'd3))
    else $error("payload result carries descriptor fields");

  a_unit_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (kind == KIND_UNIT_END) |-> last && (stream == STREAM_SAMPLE)
                                             && (nal_kind == 5'd0))
    else $error("unit end malformed");

  a_desc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (kind == KIND_DESC) |-> (out_byte == 8'd0) && !idr_seen
                                         && (nal_length != 32'd0))
    else $error("descriptor malformed");

  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (kind == KIND_PAYLOAD) || (kind == KIND_DESC) ||
                  (kind == KIND_UNIT_END))
    else $error("unused result kind");

endmodule

bind annexb_to_length_prefixed_nal_top a2l_checker u_a2l_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .out_byte   (out_if.out_byte),
  .kind       (out_if.kind),
  .stream     (out_if.stream),
  .nal_kind   (out_if.nal_kind),
  .nal_length (out_if.nal_length),
  .idr_seen   (out_if.idr_seen),
  .last       (out_if.last)
);
